@@ sv/trq_pkg.sv @@
// ---------------------------------------------------------------------------
// trq_pkg: shared types and codes of the touch report qualifier
// Holds the request, result, settings and state records plus the event,
// request kind and register index codes.
// ---------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  // Event codes carried with every result
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DOWN    = 3'd1,
    EV_UP      = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_LOST    = 3'd4,
    EV_REJECT  = 3'd5,
    EV_CANCEL  = 3'd6
  } trq_event_t;

  // Request kinds
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_RECOVER = 1'b1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_POLL_INTERVAL = 3'd0;
  localparam logic [2:0] REG_LOST_AFTER    = 3'd1;
  localparam logic [2:0] REG_SILENCE       = 3'd2;
  localparam logic [2:0] REG_SWAP_AXES     = 3'd3;
  localparam logic [2:0] REG_MIRROR_H      = 3'd4;
  localparam logic [2:0] REG_MIRROR_V      = 3'd5;
  localparam logic [2:0] REG_SCREEN_W      = 3'd6;
  localparam logic [2:0] REG_SCREEN_H      = 3'd7;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned ADDR_W     = 5;

  localparam logic [7:0]  STREAK_MAX = 8'hFF;
  localparam logic [31:0] REJECT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [7:0]  lost_after_failures;
    logic [15:0] silence_timeout_ms;
    logic        swap_axes;
    logic        mirror_horizontal;
    logic        mirror_vertical;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } trq_cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic        read_ok;
    logic        fresh;
    logic [3:0]  finger_count;
    logic        palm_flag;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } trq_item_t;

  typedef struct packed {
    logic        held;
    logic        blocked;
    logic        lost;
    logic [7:0]  failure_streak;
    logic [31:0] last_poll_time;
    logic [31:0] last_report_time;
    logic [31:0] rejected_total;
    logic [11:0] point_x;
    logic [11:0] point_y;
  } trq_state_t;

  typedef struct packed {
    trq_event_t  event_res;
    logic [11:0] mapped_x;
    logic [11:0] mapped_y;
    logic        touching;
    logic [31:0] reject_count;
    logic        controller_lost;
  } trq_result_t;

endpackage

`default_nettype wire

@@ sv/trq_cfg.sv @@
// ---------------------------------------------------------------------------
// trq_cfg: configuration register file
// APB-style write and read access to the eight qualifier settings.
// ---------------------------------------------------------------------------
`default_nettype none

module trq_cfg
  import trq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output trq_cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write the selected register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ms    <= 16'd20;
      cfg.lost_after_failures <= 8'd3;
      cfg.silence_timeout_ms  <= 16'd200;
      cfg.swap_axes           <= 1'b0;
      cfg.mirror_horizontal   <= 1'b0;
      cfg.mirror_vertical     <= 1'b0;
      cfg.screen_width        <= 13'd800;
      cfg.screen_height       <= 13'd480;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POLL_INTERVAL: cfg.poll_interval_ms    <= pwdata[15:0];
        REG_LOST_AFTER:    cfg.lost_after_failures <= pwdata[7:0];
        REG_SILENCE:       cfg.silence_timeout_ms  <= pwdata[15:0];
        REG_SWAP_AXES:     cfg.swap_axes           <= pwdata[0];
        REG_MIRROR_H:      cfg.mirror_horizontal   <= pwdata[0];
        REG_MIRROR_V:      cfg.mirror_vertical     <= pwdata[0];
        REG_SCREEN_W:      cfg.screen_width        <= pwdata[12:0];
        REG_SCREEN_H:      cfg.screen_height       <= pwdata[12:0];
        default:           ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      REG_POLL_INTERVAL: prdata = {16'd0, cfg.poll_interval_ms};
      REG_LOST_AFTER:    prdata = {24'd0, cfg.lost_after_failures};
      REG_SILENCE:       prdata = {16'd0, cfg.silence_timeout_ms};
      REG_SWAP_AXES:     prdata = {31'd0, cfg.swap_axes};
      REG_MIRROR_H:      prdata = {31'd0, cfg.mirror_horizontal};
      REG_MIRROR_V:      prdata = {31'd0, cfg.mirror_vertical};
      REG_SCREEN_W:      prdata = {19'd0, cfg.screen_width};
      REG_SCREEN_H:      prdata = {19'd0, cfg.screen_height};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/trq_core.sv @@
// ---------------------------------------------------------------------------
// trq_core: report qualification logic
// Works out the next tracker state and the result for one request.
// ---------------------------------------------------------------------------
`default_nettype none

module trq_core
  import trq_pkg::*;
(
  input  trq_cfg_t    cfg,
  input  trq_item_t   item,
  input  trq_state_t  st,
  output trq_state_t  st_next,
  output trq_result_t res
);

  logic [31:0] poll_gap;
  logic [31:0] silence_gap;
  logic        poll_early;
  logic        silent;
  logic [7:0]  streak_inc;
  logic [12:0] lim_x;
  logic [12:0] lim_y;
  logic        off_panel;
  logic [15:0] sel_x;
  logic [15:0] sel_y;
  logic [15:0] mir_x;
  logic [15:0] mir_y;
  trq_event_t  ev;

  // Time gaps modulo 2^32
  assign poll_gap    = item.now_ms - st.last_poll_time;
  assign silence_gap = item.now_ms - st.last_report_time;
  assign poll_early  = poll_gap < {16'd0, cfg.poll_interval_ms};
  assign silent      = silence_gap > {16'd0, cfg.silence_timeout_ms};
  assign streak_inc  = (st.failure_streak == STREAK_MAX) ? STREAK_MAX
                                                         : st.failure_streak + 8'd1;

  // Swap, range check and mirror the raw point
  assign lim_x     = cfg.swap_axes ? cfg.screen_height : cfg.screen_width;
  assign lim_y     = cfg.swap_axes ? cfg.screen_width  : cfg.screen_height;
  assign off_panel = (item.raw_x >= {3'd0, lim_x}) || (item.raw_y >= {3'd0, lim_y});
  assign sel_x     = cfg.swap_axes ? item.raw_y : item.raw_x;
  assign sel_y     = cfg.swap_axes ? item.raw_x : item.raw_y;
  assign mir_x     = cfg.mirror_horizontal ? ({3'd0, cfg.screen_width} - 16'd1 - sel_x)
                                           : sel_x;
  assign mir_y     = cfg.mirror_vertical   ? ({3'd0, cfg.screen_height} - 16'd1 - sel_y)
                                           : sel_y;

  // Update state for one request
  always_comb begin
    st_next = st;
    ev      = EV_NONE;
    if (item.op == OP_RECOVER) begin
      st_next.lost           = 1'b0;
      st_next.failure_streak = 8'd0;
    end else if (!st.lost && !poll_early) begin
      st_next.last_poll_time = item.now_ms;
      if (!item.read_ok) begin
        st_next.failure_streak = streak_inc;
        if (streak_inc >= cfg.lost_after_failures) begin
          st_next.lost    = 1'b1;
          st_next.held    = 1'b0;
          st_next.blocked = 1'b0;
          ev              = EV_LOST;
        end
      end else begin
        st_next.failure_streak = 8'd0;
        if (!item.fresh) begin
          // Release a touch after too long without fresh data
          if ((st.held || st.blocked) && silent) begin
            st_next.held    = 1'b0;
            st_next.blocked = 1'b0;
            ev              = EV_TIMEOUT;
          end
        end else begin
          st_next.last_report_time = item.now_ms;
          if (item.finger_count == 4'd0) begin
            if (st.held || st.blocked) ev = EV_UP;
            st_next.held    = 1'b0;
            st_next.blocked = 1'b0;
          end else if (item.palm_flag || item.finger_count > 4'd1) begin
            // Block on palm or multi-finger contact
            if (!st.blocked) ev = EV_CANCEL;
            st_next.blocked = 1'b1;
          end else if (!st.blocked) begin
            if (off_panel) begin
              if (st.rejected_total != REJECT_MAX) begin
                st_next.rejected_total = st.rejected_total + 32'd1;
              end
              ev = EV_REJECT;
            end else begin
              st_next.point_x = mir_x[11:0];
              st_next.point_y = mir_y[11:0];
              if (!st.held) begin
                st_next.held = 1'b1;
                ev           = EV_DOWN;
              end
            end
          end
        end
      end
    end
  end

  // Result reflects the state after the request
  always_comb begin
    res.event_res       = ev;
    res.mapped_x        = st_next.point_x;
    res.mapped_y        = st_next.point_y;
    res.touching        = st_next.held | st_next.blocked;
    res.reject_count    = st_next.rejected_total;
    res.controller_lost = st_next.lost;
  end

endmodule

`default_nettype wire

@@ sv/touch_report_qualifier.sv @@
// ---------------------------------------------------------------------------
// touch_report_qualifier: touch controller report qualifier
// Turns polled touch reports into touch-down, touch-up and fault events.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the kind (poll report
//   or controller recovered), s_tdata the time stamp and report fields.
//   Every request gives exactly one result on the m_ channel: m_tuser holds
//   the event code, m_tdata the last accepted point, touch, reject count and
//   lost flags as they stand after the request.
//   Settings must be written through the APB-style port only while no
//   request is in flight; the block itself does not enforce this.
//   Each request is taken into the input register, then passes once through
//   the qualifier logic into the result register, which drives m_tvalid.
//   Throughput: one request per cycle while m_tready stays high; the result
//   register and the input register form a two-entry pipe, so a request is
//   still taken while one result waits.
//   Reset clears both pipe stages, the tracker state and restores default
//   settings. When the receiver stalls, the result holds and the input
//   register fills, after which s_tready drops until m_tready returns.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_report_qualifier
  import trq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Requests
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [31:0] now_ms, [32] read_ok, [33] fresh, [37:34] finger_count,
  // [38] palm_flag, [54:39] raw_x, [70:55] raw_y, [71] zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  wire logic                  s_tuser,
  // Results
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [11:0] mapped_x, [23:12] mapped_y, [24] touching, [56:25] reject_count,
  // [57] controller_lost, [63:58] zero
  output logic      [OUT_DATA_W-1:0] m_tdata,
  // [2:0] event_res
  output logic      [2:0]            m_tuser,
  // Configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  trq_cfg_t    cfg;
  trq_item_t   in_item;
  logic        in_valid;
  trq_state_t  st;
  trq_state_t  st_next;
  trq_result_t res;
  trq_result_t out_res;
  logic        advance;

  trq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trq_core u_core (
    .cfg     (cfg),
    .item    (in_item),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // Move a request into the result register when that slot frees up
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op           <= s_tuser;
      in_item.now_ms       <= s_tdata[31:0];
      in_item.read_ok      <= s_tdata[32];
      in_item.fresh        <= s_tdata[33];
      in_item.finger_count <= s_tdata[37:34];
      in_item.palm_flag    <= s_tdata[38];
      in_item.raw_x        <= s_tdata[54:39];
      in_item.raw_y        <= s_tdata[70:55];
    end
  end

  // Tracker state advances with each request
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.event_res;
  assign m_tdata = {6'd0, out_res.controller_lost, out_res.reject_count,
                    out_res.touching, out_res.mapped_y, out_res.mapped_x};

endmodule

`default_nettype wire

@@ sv/trq_checker.sv @@
// ---------------------------------------------------------------------------
// trq_checker: port-level checks of the touch report qualifier
// Watches the result channel for consistency of events and flags.
// ---------------------------------------------------------------------------
`default_nettype none

module trq_checker
  import trq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [2:0]            m_tuser
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Lost event leaves controller lost and touch released
  a_lost_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_LOST) |-> m_tdata[57] && !m_tdata[24])
    else $error("lost event with inconsistent flags");

  // Down and cancel leave a touch, up and timeout release it
  a_touch_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == EV_DOWN) || (m_tuser == EV_CANCEL)) |-> m_tdata[24])
    else $error("touch flag low after down or cancel");

  a_release_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == EV_UP) || (m_tuser == EV_TIMEOUT)) |-> !m_tdata[24])
    else $error("touch flag high after release");

endmodule

bind touch_report_qualifier trq_checker u_trq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
